// File: src/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

	// Largest block count a request may ask for
	localparam int unsigned BLOCK_LIMIT = 16;

	// Header and body layout
	localparam int unsigned ID_LEN       = 8;
	localparam int unsigned HDR_SOURCE   = 13;
	localparam int unsigned HDR_INV_LO   = 14;
	localparam int unsigned HDR_INV_HI   = 15;
	localparam int unsigned HDR_LEN_LO   = 16;
	localparam int unsigned HDR_LEN_HI   = 17;
	localparam int unsigned HDR_LAST     = 19;
	localparam int unsigned BODY_ERR_LO  = 6;
	localparam int unsigned BODY_ERR_HI  = 7;
	localparam int unsigned BODY_CNT_LO  = 8;
	localparam int unsigned BODY_CNT_HI  = 9;
	localparam int unsigned BODY_MIN     = 8;
	localparam int unsigned BODY_MIN_CNT = 10;

	// Frame status codes
	localparam logic [3:0] ST_BUSY       = 4'd0;
	localparam logic [3:0] ST_OK         = 4'd1;
	localparam logic [3:0] ST_BAD_ID     = 4'd2;
	localparam logic [3:0] ST_BAD_SOURCE = 4'd3;
	localparam logic [3:0] ST_BAD_INVOKE = 4'd4;
	localparam logic [3:0] ST_SHORT      = 4'd5;
	localparam logic [3:0] ST_DEV_ERR    = 4'd6;
	localparam logic [3:0] ST_COUNT      = 4'd7;
	localparam logic [3:0] ST_OVERRUN    = 4'd8;

	localparam logic [7:0] SOURCE_RESET = 8'd17;

	// Eight-byte company id at the head of every response
	function automatic logic [7:0] company_tag(input logic [2:0] idx);
		logic [7:0] t;
		unique case (idx)
			3'd0: t = 8'h4C;
			3'd1: t = 8'h53;
			3'd2: t = 8'h49;
			3'd3: t = 8'h53;
			3'd4: t = 8'h2D;
			3'd5: t = 8'h58;
			3'd6: t = 8'h47;
			3'd7: t = 8'h54;
		endcase
		return t;
	endfunction

	// One result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic [3:0] block_index;
		logic       block_last;
		logic       block_empty;
		logic       frame_done;
		logic [3:0] status;
	} result_t;

endpackage

// File: src/read_response_deframer_core.sv
`timescale 1ns / 1ps

// Channel  | Direction | Contents
// s_axis   | in        | tdata: rx_byte, expected_invoke, expected_blocks; tuser: frame_start
// m_axis   | out       | tdata: data_byte, block_index, status; tuser: data_valid,
//          |           |   block_empty, frame_done; tlast: block_last
// cfg      | in        | cfg_wr_en / cfg_wr_data: server_source
//
// One result word per input word; a word is accepted every cycle.
// Each accepted byte goes through the parser in the cycle it is taken and the
// result lands in the output register, so it appears on m_axis in the next cycle.
// The input stalls only when the output register is full and m_axis_tready is low.
// arst_n clears the parser to idle and sets server_source to 17.
module read_response_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] expected_invoke,
	                                    // [28:24] expected_blocks, [31:29] zero
	input  logic [0:0]  s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] block_index, [15:12] status
	output logic [2:0]  m_axis_tuser,   // [0] data_valid, [1] block_empty, [2] frame_done
	output logic        m_axis_tlast,   // block_last
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import rrd_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_DATA   = 2'd3;

	// Parser state
	logic [7:0]  server_source_q;
	logic [1:0]  phase_q;
	logic [4:0]  header_pos_q;
	logic [15:0] body_length_q;
	logic [15:0] body_pos_q;
	logic [7:0]  held_low_q;
	logic [15:0] invoke_q;
	logic [4:0]  blocks_wanted_q;
	logic [4:0]  blocks_seen_q;
	logic [15:0] block_left_q;
	logic        len_high_q;

	// Output register
	logic        out_valid_q;
	result_t     out_q;

	// Input fields
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic [15:0] expected_invoke;
	logic [4:0]  expected_blocks;
	logic        accept;

	assign rx_byte         = s_axis_tdata[7:0];
	assign expected_invoke = s_axis_tdata[23:8];
	assign expected_blocks = s_axis_tdata[28:24];
	assign frame_start     = s_axis_tuser[0];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// State as seen by this byte (a frame start restarts the frame)
	logic [1:0]  cur_phase;
	logic [4:0]  cur_hpos;
	logic [15:0] cur_blen;
	logic [15:0] cur_bpos;
	logic [15:0] cur_inv;
	logic [4:0]  cur_want;
	logic [4:0]  cur_seen;
	logic [15:0] cur_left;
	logic        cur_len_high;

	always_comb begin
		if (frame_start) begin
			cur_phase    = PH_HEADER;
			cur_hpos     = '0;
			cur_blen     = '0;
			cur_bpos     = '0;
			cur_inv      = expected_invoke;
			cur_want     = expected_blocks;
			cur_seen     = '0;
			cur_left     = '0;
			cur_len_high = 1'b0;
		end else begin
			cur_phase    = phase_q;
			cur_hpos     = header_pos_q;
			cur_blen     = body_length_q;
			cur_bpos     = body_pos_q;
			cur_inv      = invoke_q;
			cur_want     = blocks_wanted_q;
			cur_seen     = blocks_seen_q;
			cur_left     = block_left_q;
			cur_len_high = len_high_q;
		end
	end

	// Next state and result for this byte
	logic [1:0]  nxt_phase;
	logic [4:0]  nxt_hpos;
	logic [15:0] nxt_blen;
	logic [15:0] nxt_bpos;
	logic [7:0]  nxt_held;
	logic [4:0]  nxt_seen;
	logic [15:0] nxt_left;
	logic        nxt_len_high;
	result_t     res;

	logic [16:0] next_pos;
	logic [17:0] end_pos;
	logic [15:0] word;
	logic [4:0]  seen_inc;
	logic [15:0] left_dec;
	logic        want_bad;

	assign next_pos = {1'b0, cur_bpos} + 17'd1;
	assign word     = {rx_byte, held_low_q};
	assign end_pos  = {1'b0, next_pos} + {2'b00, word};
	assign seen_inc = cur_seen + 5'd1;
	assign left_dec = cur_left - 16'd1;
	assign want_bad = (cur_want == 5'd0) || (32'(cur_want) > BLOCK_LIMIT);

	always_comb begin
		nxt_phase    = cur_phase;
		nxt_hpos     = cur_hpos;
		nxt_blen     = cur_blen;
		nxt_bpos     = cur_bpos;
		nxt_held     = held_low_q;
		nxt_seen     = cur_seen;
		nxt_left     = cur_left;
		nxt_len_high = cur_len_high;
		res          = '0;

		unique case (cur_phase)
			PH_IDLE: begin
			end

			PH_HEADER: begin
				nxt_hpos = cur_hpos + 5'd1;
				if (32'(cur_hpos) < ID_LEN) begin
					if (rx_byte != company_tag(cur_hpos[2:0])) begin
						res.frame_done = 1'b1;
						res.status     = ST_BAD_ID;
						nxt_phase      = PH_IDLE;
					end
				end else if (32'(cur_hpos) == HDR_SOURCE) begin
					if (rx_byte != server_source_q) begin
						res.frame_done = 1'b1;
						res.status     = ST_BAD_SOURCE;
						nxt_phase      = PH_IDLE;
					end
				end else if (32'(cur_hpos) == HDR_INV_LO || 32'(cur_hpos) == HDR_LEN_LO) begin
					nxt_held = rx_byte;
				end else if (32'(cur_hpos) == HDR_INV_HI) begin
					if (word != cur_inv) begin
						res.frame_done = 1'b1;
						res.status     = ST_BAD_INVOKE;
						nxt_phase      = PH_IDLE;
					end
				end else if (32'(cur_hpos) == HDR_LEN_HI) begin
					nxt_blen = word;
				end else if (32'(cur_hpos) >= HDR_LAST) begin
					if (32'(cur_blen) < BODY_MIN) begin
						res.frame_done = 1'b1;
						res.status     = ST_SHORT;
						nxt_phase      = PH_IDLE;
					end else begin
						nxt_phase    = PH_BODY;
						nxt_bpos     = '0;
						nxt_seen     = '0;
						nxt_len_high = 1'b0;
					end
				end
			end

			PH_BODY: begin
				nxt_bpos = next_pos[15:0];
				if (32'(cur_bpos) < BODY_ERR_LO) begin
				end else if (32'(cur_bpos) == BODY_ERR_LO || 32'(cur_bpos) == BODY_CNT_LO) begin
					nxt_held = rx_byte;
				end else if (32'(cur_bpos) == BODY_ERR_HI) begin
					if (word != 16'd0) begin
						res.frame_done = 1'b1;
						res.status     = ST_DEV_ERR;
						nxt_phase      = PH_IDLE;
					end else if (32'(cur_blen) < BODY_MIN_CNT) begin
						res.frame_done = 1'b1;
						res.status     = ST_SHORT;
						nxt_phase      = PH_IDLE;
					end
				end else if (32'(cur_bpos) == BODY_CNT_HI) begin
					if (want_bad || word != {11'd0, cur_want}) begin
						res.frame_done = 1'b1;
						res.status     = ST_COUNT;
						nxt_phase      = PH_IDLE;
					end else if (next_pos >= {1'b0, cur_blen}) begin
						res.frame_done = 1'b1;
						res.status     = ST_OVERRUN;
						nxt_phase      = PH_IDLE;
					end else begin
						nxt_len_high = 1'b0;
					end
				end else if (!cur_len_high) begin
					// low byte of a block length
					nxt_held     = rx_byte;
					nxt_len_high = 1'b1;
					if (next_pos >= {1'b0, cur_blen}) begin
						res.frame_done = 1'b1;
						res.status     = ST_OVERRUN;
						nxt_phase      = PH_IDLE;
					end
				end else begin
					// high byte of a block length
					nxt_len_high = 1'b0;
					if (end_pos > {2'b00, cur_blen}) begin
						res.frame_done = 1'b1;
						res.status     = ST_OVERRUN;
						nxt_phase      = PH_IDLE;
					end else if (word == 16'd0) begin
						res.block_empty = 1'b1;
						res.block_index = cur_seen[3:0];
						nxt_seen        = seen_inc;
						if (seen_inc == cur_want) begin
							res.frame_done = 1'b1;
							res.status     = ST_OK;
							nxt_phase      = PH_IDLE;
						end else if (next_pos >= {1'b0, cur_blen}) begin
							res.frame_done = 1'b1;
							res.status     = ST_OVERRUN;
							nxt_phase      = PH_IDLE;
						end
					end else begin
						nxt_left  = word;
						nxt_phase = PH_DATA;
					end
				end
			end

			PH_DATA: begin
				nxt_bpos        = next_pos[15:0];
				res.data_byte   = rx_byte;
				res.data_valid  = 1'b1;
				res.block_index = cur_seen[3:0];
				nxt_left        = left_dec;
				if (left_dec == 16'd0) begin
					res.block_last = 1'b1;
					nxt_seen       = seen_inc;
					nxt_phase      = PH_BODY;
					nxt_len_high   = 1'b0;
					if (seen_inc == cur_want) begin
						res.frame_done = 1'b1;
						res.status     = ST_OK;
						nxt_phase      = PH_IDLE;
					end else if (next_pos >= {1'b0, cur_blen}) begin
						res.frame_done = 1'b1;
						res.status     = ST_OVERRUN;
						nxt_phase      = PH_IDLE;
					end
				end
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_source_q <= SOURCE_RESET;
		end else if (cfg_wr_en) begin
			server_source_q <= cfg_wr_data;
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			header_pos_q    <= '0;
			body_length_q   <= '0;
			body_pos_q      <= '0;
			held_low_q      <= '0;
			invoke_q        <= '0;
			blocks_wanted_q <= '0;
			blocks_seen_q   <= '0;
			block_left_q    <= '0;
			len_high_q      <= 1'b0;
		end else if (accept) begin
			phase_q         <= nxt_phase;
			header_pos_q    <= nxt_hpos;
			body_length_q   <= nxt_blen;
			body_pos_q      <= nxt_bpos;
			held_low_q      <= nxt_held;
			invoke_q        <= cur_inv;
			blocks_wanted_q <= cur_want;
			blocks_seen_q   <= nxt_seen;
			block_left_q    <= nxt_left;
			len_high_q      <= nxt_len_high;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.status, out_q.block_index, out_q.data_byte};
	assign m_axis_tuser  = {out_q.frame_done, out_q.block_empty, out_q.data_valid};
	assign m_axis_tlast  = out_q.block_last;

endmodule

// File: test/rrd_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the config port, predicts one result word per accepted
// input word, and compares each accepted output word against the oldest prediction.
module rrd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] expected_invoke,
	                                    // [28:24] expected_blocks
	input  logic [0:0]  s_axis_tuser,   // [0] frame_start
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] block_index, [15:12] status
	input  logic [2:0]  m_axis_tuser,   // [0] data_valid, [1] block_empty, [2] frame_done
	input  logic        m_axis_tlast,   // block_last
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          frames_closed
);

	import rrd_pkg::*;

	typedef enum logic [1:0] {P_IDLE, P_HEADER, P_BODY, P_DATA} parse_phase_t;

	// Company id, first byte in the low bits
	localparam logic [63:0] ID_STRING = 64'h54_47_58_2D_53_49_53_4C;

	// Parser state mirrored here
	logic [7:0]   src_byte;
	parse_phase_t parse_phase;
	logic [4:0]   hdr_pos;
	logic [15:0]  body_len;
	logic [15:0]  body_pos;
	logic [7:0]   low_hold;
	logic [15:0]  inv_latch;
	logic [4:0]   want_cnt;
	logic [4:0]   seen_cnt;
	logic [15:0]  blk_left;
	logic         len_hi;

	result_t predicted_q[$];
	result_t predicted;
	result_t observed;
	int      bad_fields;

	task automatic close_frame(inout result_t r, input logic [3:0] code);
		r.frame_done = 1'b1;
		r.status = code;
		parse_phase = P_IDLE;
	endtask

	// A block just finished: close the frame if it was the last one or if the body ran out
	task automatic block_closed(inout result_t r, input int unsigned nxt);
		seen_cnt = seen_cnt + 5'd1;
		if (seen_cnt == want_cnt)
			close_frame(r, ST_OK);
		else if (nxt >= body_len)
			close_frame(r, ST_OVERRUN);
	endtask

	task automatic predict_word(input logic [7:0] b, input logic start,
			input logic [15:0] inv, input logic [4:0] nb, output result_t r);
		logic [4:0]  hp;
		int unsigned p;
		int unsigned nxt;
		logic [15:0] word;
		r = '0;
		if (start) begin
			parse_phase = P_HEADER;
			hdr_pos = '0;
			body_len = '0;
			body_pos = '0;
			seen_cnt = '0;
			blk_left = '0;
			len_hi = 1'b0;
			inv_latch = inv;
			want_cnt = nb;
		end
		word = {b, low_hold};
		case (parse_phase)
			P_HEADER: begin
				hp = hdr_pos;
				hdr_pos = hdr_pos + 5'd1;
				if (hp < ID_LEN) begin
					if (b != ID_STRING[hp[2:0] * 8 +: 8])
						close_frame(r, ST_BAD_ID);
				end else if (hp == HDR_SOURCE) begin
					if (b != src_byte)
						close_frame(r, ST_BAD_SOURCE);
				end else if (hp == HDR_INV_LO || hp == HDR_LEN_LO) begin
					low_hold = b;
				end else if (hp == HDR_INV_HI) begin
					if (word != inv_latch)
						close_frame(r, ST_BAD_INVOKE);
				end else if (hp == HDR_LEN_HI) begin
					body_len = word;
				end else if (hp >= HDR_LAST) begin
					if (body_len < BODY_MIN) begin
						close_frame(r, ST_SHORT);
					end else begin
						parse_phase = P_BODY;
						body_pos = '0;
						seen_cnt = '0;
						len_hi = 1'b0;
					end
				end
			end
			P_BODY: begin
				p = body_pos;
				nxt = p + 1;
				body_pos = nxt[15:0];
				if (p == BODY_ERR_LO || p == BODY_CNT_LO) begin
					low_hold = b;
				end else if (p == BODY_ERR_HI) begin
					if (word != 16'd0)
						close_frame(r, ST_DEV_ERR);
					else if (body_len < BODY_MIN_CNT)
						close_frame(r, ST_SHORT);
				end else if (p == BODY_CNT_HI) begin
					if (want_cnt == 5'd0 || want_cnt > BLOCK_LIMIT || word != want_cnt)
						close_frame(r, ST_COUNT);
					else if (nxt >= body_len)
						close_frame(r, ST_OVERRUN);
					else
						len_hi = 1'b0;
				end else if (p > BODY_CNT_HI) begin
					if (!len_hi) begin
						// block length, low byte
						low_hold = b;
						len_hi = 1'b1;
						if (nxt >= body_len)
							close_frame(r, ST_OVERRUN);
					end else begin
						len_hi = 1'b0;
						if (nxt + word > body_len) begin
							close_frame(r, ST_OVERRUN);
						end else if (word == 16'd0) begin
							r.block_empty = 1'b1;
							r.block_index = seen_cnt[3:0];
							block_closed(r, nxt);
						end else begin
							blk_left = word;
							parse_phase = P_DATA;
						end
					end
				end
			end
			P_DATA: begin
				nxt = body_pos + 1;
				body_pos = nxt[15:0];
				r.data_byte = b;
				r.data_valid = 1'b1;
				r.block_index = seen_cnt[3:0];
				blk_left = blk_left - 16'd1;
				if (blk_left == 16'd0) begin
					r.block_last = 1'b1;
					parse_phase = P_BODY;
					len_hi = 1'b0;
					block_closed(r, nxt);
				end
			end
			default: ;
		endcase
	endtask

	function automatic int field_diff(string name, int unsigned want, int unsigned got);
		if (want == got)
			return 0;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	// Output side first: a result leaving now belongs to an earlier input word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_byte = SOURCE_RESET;
			parse_phase = P_IDLE;
			hdr_pos = '0;
			body_len = '0;
			body_pos = '0;
			low_hold = '0;
			inv_latch = '0;
			want_cnt = '0;
			seen_cnt = '0;
			blk_left = '0;
			len_hi = 1'b0;
			predicted_q.delete();
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
			frames_closed <= 0;
		end else begin
			if (cfg_wr_en)
				src_byte = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				observed.data_byte = m_axis_tdata[7:0];
				observed.block_index = m_axis_tdata[11:8];
				observed.status = m_axis_tdata[15:12];
				observed.data_valid = m_axis_tuser[0];
				observed.block_empty = m_axis_tuser[1];
				observed.frame_done = m_axis_tuser[2];
				observed.block_last = m_axis_tlast;
				if (predicted_q.size() == 0) begin
					$display("%0t ns: result word with nothing expected, actual %h",
						$time, observed);
					fail_count <= fail_count + 1;
				end else begin
					predicted = predicted_q.pop_front();
					bad_fields = field_diff("data_byte", predicted.data_byte, observed.data_byte)
						+ field_diff("data_valid", predicted.data_valid, observed.data_valid)
						+ field_diff("block_index", predicted.block_index, observed.block_index)
						+ field_diff("block_last", predicted.block_last, observed.block_last)
						+ field_diff("block_empty", predicted.block_empty, observed.block_empty)
						+ field_diff("frame_done", predicted.frame_done, observed.frame_done)
						+ field_diff("status", predicted.status, observed.status);
					if (bad_fields != 0)
						fail_count <= fail_count + 1;
					words_checked <= words_checked + 1;
					if (predicted.frame_done)
						frames_closed <= frames_closed + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tdata[23:8],
					s_axis_tdata[28:24], predicted);
				predicted_q = {predicted_q, predicted};
			end
			pending <= predicted_q.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Drives response frames into the deframer, mostly well-formed with random content
// plus every kind of broken frame, under random stalls on both streams.
module tb;

	import rrd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS = 340;

	typedef enum int {
		FR_GOOD, FR_TRAILING, FR_BAD_ID, FR_BAD_SOURCE, FR_BAD_INVOKE, FR_SHORT_HDR,
		FR_SHORT_BODY, FR_DEV_ERR, FR_BAD_COUNT, FR_BAD_WANT, FR_OVERRUN, FR_CUT
	} frame_kind_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	int   fail_count;
	int   pending;
	int   words_checked;
	int   frames_closed;

	logic [7:0] cur_source = SOURCE_RESET;
	bit         idle_on = 1'b1;
	int         words_sent = 0;
	int         frames_sent = 0;
	int         stall_left = 0;
	int         stuck;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	read_response_deframer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	rrd_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count),
		.pending(pending),
		.words_checked(words_checked),
		.frames_closed(frames_closed)
	);

	// Receiver backpressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 14);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Stop if nothing moves on either stream for too long
	initial begin
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stuck = 0;
			else
				stuck = stuck + 1;
		end
		$display("TEST FAILED");
		$finish;
	end

	// One input word; returns at the edge where it is taken
	task automatic send_word(input logic [7:0] b, input logic start,
			input logic [15:0] inv, input logic [4:0] nb);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, nb, inv, b};
		s_axis_tuser <= start;
		do
			@(posedge clk);
		while (!s_axis_tready);
		words_sent = words_sent + 1;
	endtask

	// Non-start word: invoke and block fields carry noise
	task automatic send_payload(input logic [7:0] b);
		send_word(b, 1'b0, 16'($urandom), 5'($urandom_range(0, 31)));
	endtask

	// Hold the sender until every result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_source(input logic [7:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_source = v;
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0]  fr[$];
		logic [7:0]  body[$];
		logic [15:0] inv;
		logic [15:0] hdr_inv;
		logic [15:0] declared;
		logic [15:0] err_word;
		logic [15:0] cnt_word;
		logic [4:0]  want;
		logic [7:0]  src;
		int          n_build;
		int          blen;
		int          sel;
		int          last_len_pos;
		int          k;
		int          len;

		inv = 16'($urandom);
		hdr_inv = inv;
		src = cur_source;
		if (kind == FR_BAD_WANT)
			want = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
		else if ($urandom_range(0, 4) != 0)
			want = 5'($urandom_range(1, 4));
		else
			want = 5'($urandom_range(1, BLOCK_LIMIT));
		n_build = (want >= 1 && want <= BLOCK_LIMIT) ? int'(want) :
			int'($urandom_range(1, 3));

		// body: command, type, reserved, error word, block count, blocks
		err_word = 16'd0;
		if (kind == FR_DEV_ERR || (kind == FR_SHORT_BODY && $urandom_range(0, 2) == 0))
			err_word = 16'($urandom_range(1, 65535));
		cnt_word = 16'(want);
		if (kind == FR_BAD_COUNT)
			cnt_word = 16'(want) + 16'($urandom_range(1, 65535));
		repeat (6) body = {body, 8'($urandom)};
		body = {body, err_word[7:0]};
		body = {body, err_word[15:8]};
		body = {body, cnt_word[7:0]};
		body = {body, cnt_word[15:8]};
		last_len_pos = 0;
		for (k = 0; k < n_build; k++) begin
			sel = $urandom_range(0, 99);
			blen = (sel < 30) ? 0 : (sel < 95) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			last_len_pos = body.size();
			body = {body, blen[7:0]};
			body = {body, blen[15:8]};
			repeat (blen) body = {body, 8'($urandom)};
		end
		declared = 16'(body.size());

		case (kind)
			FR_SHORT_HDR: declared = 16'($urandom_range(0, BODY_MIN - 1));
			FR_SHORT_BODY: declared = 16'($urandom_range(BODY_MIN, BODY_MIN_CNT - 1));
			FR_OVERRUN: begin
				if ($urandom_range(0, 1) == 0) begin
					declared = 16'($urandom_range(BODY_MIN_CNT, body.size() - 1));
				end else begin
					// last block claims far more than the body holds
					body[last_len_pos] = 8'($urandom);
					body[last_len_pos + 1] = 8'($urandom_range(1, 255));
				end
			end
			FR_CUT: if ($urandom_range(0, 1) == 0) declared = 16'($urandom);
			FR_BAD_SOURCE: src = cur_source ^ 8'($urandom_range(1, 255));
			FR_BAD_INVOKE: hdr_inv = inv ^ 16'($urandom_range(1, 65535));
			default: ;
		endcase

		// 20-byte header
		for (k = 0; k < ID_LEN; k++)
			fr = {fr, company_tag(k[2:0])};
		if (kind == FR_BAD_ID) begin
			k = $urandom_range(0, ID_LEN - 1);
			fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
		end
		repeat (HDR_SOURCE - ID_LEN) fr = {fr, 8'($urandom)};
		fr = {fr, src};
		fr = {fr, hdr_inv[7:0]};
		fr = {fr, hdr_inv[15:8]};
		fr = {fr, declared[7:0]};
		fr = {fr, declared[15:8]};
		fr = {fr, 8'($urandom)};
		fr = {fr, 8'($urandom)};
		fr = {fr, body};
		if (kind == FR_TRAILING)
			repeat ($urandom_range(1, 5)) fr = {fr, 8'($urandom)};
		len = (kind == FR_CUT) ? $urandom_range(1, fr.size() - 1) : fr.size();

		send_word(fr[0], 1'b1, inv, want);
		for (k = 1; k < len; k++)
			send_payload(fr[k]);
		frames_sent = frames_sent + 1;

		// a little noise between frames
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
	endtask

	initial begin
		int          ph;
		int          r;
		frame_kind_t kind;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle bytes at the extremes, id failing on its first byte,
		// restart in the middle of a header, idle byte after an abort
		send_word(8'h00, 1'b0, 16'h0000, 5'd0);
		send_word(8'hFF, 1'b0, 16'hFFFF, 5'd31);
		send_word(8'hFF, 1'b1, 16'hFFFF, 5'd31);
		send_word(company_tag(3'd0), 1'b1, 16'h0000, 5'd1);
		send_payload(company_tag(3'd1));
		send_word(company_tag(3'd0), 1'b1, 16'h1234, 5'd16);
		send_payload(8'h00);
		send_payload(8'h5A);

		// Random frames over several source settings; the last setting runs unstalled
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_source(8'h00);
				2: write_source(8'hFF);
				3, 4: write_source(8'($urandom));
				default: ;
			endcase
			if (ph == 4)
				idle_on = 1'b0;
			while (words_sent < (ph + 1) * PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					kind = FR_GOOD;
				else if (r < 55)
					kind = FR_TRAILING;
				else
					kind = frame_kind_t'(FR_BAD_ID + (r - 55) % 10);
				send_frame(kind);
			end
			// leave the parser idle before the next register write
			send_frame(FR_GOOD);
		end

		drain();
		repeat (4) @(posedge clk);
		$display("Sent %0d words in %0d frames over 5 source settings,",
			words_sent, frames_sent);
		$display("all frame errors mixed in; %0d result words compared, %0d frames ended.",
			words_checked, frames_closed);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
